@@ src/sfcrc_pkg.sv @@
package sfcrc_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_crc;
    typedef logic [0:0]  t_cfg_idx;

    localparam t_cfg_idx CFG_MAGIC   = 1'd0;
    localparam t_cfg_idx CFG_VERSION = 1'd1;

    localparam t_byte MAGIC_RESET   = 8'hA7;
    localparam t_byte VERSION_RESET = 8'h01;

    localparam int HEADER_BYTES = 7;
    localparam int HDR_MAGIC    = 0;
    localparam int HDR_VERSION  = 1;
    localparam int HDR_SCAN     = 2;
    localparam int HDR_FRAG     = 3;
    localparam int HDR_LEN      = 4;
    localparam int HDR_CRC_LO   = 5;
    localparam int HDR_CRC_HI   = 6;

    localparam t_crc CRC_POLY = 16'h1021;
    localparam t_crc CRC_INIT = 16'hFFFF;
    localparam t_crc CRC_TOP  = 16'h8000;

    function automatic t_crc crc16_byte(t_crc crc_in, t_byte data);
        t_crc c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != '0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

@@ src/sfcrc_in_if.sv @@
interface sfcrc_in_if;
    logic                valid;
    logic                ready;
    sfcrc_pkg::t_byte    data_byte;
    logic                end_of_scan;

    modport source (output valid, output data_byte, output end_of_scan, input ready);
    modport sink   (input valid, input data_byte, input end_of_scan, output ready);
endinterface

@@ src/sfcrc_out_if.sv @@
interface sfcrc_out_if;
    logic                valid;
    logic                ready;
    sfcrc_pkg::t_byte    frame_byte;
    logic                frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

@@ src/sfcrc_crc_unit.sv @@
module sfcrc_crc_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic            i_en,
    input  sfcrc_pkg::t_byte i_byte,
    output sfcrc_pkg::t_crc  o_crc
);
    import sfcrc_pkg::*;

    t_crc r_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else if (i_clear) begin
            r_crc <= CRC_INIT;
        end else if (i_en) begin
            r_crc <= crc16_byte(r_crc, i_byte);
        end
    end

    assign o_crc = r_crc;

endmodule

@@ src/scan_fragment_framer_crc16_unit.sv @@
// Scan fragment framer. Scan bytes are buffered into fragments of up to
// PAYLOAD_BYTES bytes; a full fragment or the last byte of a scan produces one
// frame of 7 + PAYLOAD_BYTES bytes (magic, version, scan number, fragment
// number, length, CRC16-CCITT low/high, payload zero-padded). A byte that
// closes no fragment is only buffered. Once a closing byte is buffered, a
// byte-wide CRC unit walks the 7 + len bytes of the header and the buffered
// payload one byte a cycle, then the frame is streamed at one byte per cycle
// while the sink is ready; no input is taken during the CRC pass or the
// frame stream. The payload buffer needs no clear after reset.
module scan_fragment_framer_crc16_unit #(
    parameter int PAYLOAD_BYTES = 25
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sfcrc_in_if.sink             i_in,
    sfcrc_out_if.source          o_frame,
    input  logic                 i_cfg_we,
    input  sfcrc_pkg::t_cfg_idx  i_cfg_idx,
    input  sfcrc_pkg::t_byte     i_cfg_wdata
);
    import sfcrc_pkg::*;

    localparam int FRAME_BYTES = HEADER_BYTES + PAYLOAD_BYTES;
    localparam int IW = $clog2(FRAME_BYTES + 1);
    localparam int FW = $clog2(PAYLOAD_BYTES + 1);
    localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CRC  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]    r_state;
    logic [IW-1:0] r_idx;
    logic [FW-1:0] r_fill;
    logic          r_last;
    t_byte         r_scan;
    t_byte         r_frag;
    t_byte         r_magic;
    t_byte         r_version;
    t_byte         r_mem [PAYLOAD_BYTES];
    t_byte         r_rd;
    logic          r_out_valid;
    t_byte         r_out_byte;
    logic          r_out_end;

    logic          accept;
    logic [FW-1:0] fill_inc;
    logic          frame_due;
    logic          emit_adv;
    logic          crc_step;
    logic          adv;
    logic [IW-1:0] rd_pos;
    logic [IW-1:0] rd_off;
    logic          rd_hit;
    logic [IW-1:0] pay_off;
    logic          pay_used;
    logic          idx_last_crc;
    logic          idx_last_frame;
    t_byte         cur_byte;
    t_crc          crc;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid & i_in.ready;
    assign fill_inc   = r_fill + FW'(1);
    assign frame_due  = (fill_inc == FW'(PAYLOAD_BYTES)) || i_in.end_of_scan;
    assign emit_adv   = (r_state == S_EMIT) && (!r_out_valid || o_frame.ready);
    assign crc_step   = (r_state == S_CRC);
    assign adv        = emit_adv | crc_step;

    // prefetch the payload byte for the position about to be used
    assign rd_pos = adv ? (r_idx + IW'(1)) : r_idx;
    assign rd_off = rd_pos - IW'(HEADER_BYTES);
    assign rd_hit = (rd_pos >= IW'(HEADER_BYTES)) && (rd_off < IW'(r_fill));

    assign pay_off  = r_idx - IW'(HEADER_BYTES);
    assign pay_used = (r_idx >= IW'(HEADER_BYTES)) && (pay_off < IW'(r_fill));

    assign idx_last_crc   = (r_idx == (IW'(HEADER_BYTES) + IW'(r_fill) - IW'(1)));
    assign idx_last_frame = (r_idx == IW'(FRAME_BYTES - 1));

    always_comb begin
        case (r_idx)
            IW'(HDR_MAGIC):   cur_byte = r_magic;
            IW'(HDR_VERSION): cur_byte = r_version;
            IW'(HDR_SCAN):    cur_byte = r_scan;
            IW'(HDR_FRAG):    cur_byte = r_frag;
            IW'(HDR_LEN):     cur_byte = t_byte'(r_fill);
            IW'(HDR_CRC_LO):  cur_byte = (r_state == S_EMIT) ? crc[7:0] : '0;
            IW'(HDR_CRC_HI):  cur_byte = (r_state == S_EMIT) ? crc[15:8] : '0;
            default:          cur_byte = pay_used ? r_rd : '0;
        endcase
    end

    sfcrc_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (accept & frame_due),
        .i_en    (crc_step),
        .i_byte  (cur_byte),
        .o_crc   (crc)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_fill[AW-1:0]] <= i_in.data_byte;
        end
        if (rd_hit) begin
            r_rd <= r_mem[rd_off[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= MAGIC_RESET;
            r_version <= VERSION_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAGIC:   r_magic   <= i_cfg_wdata;
                CFG_VERSION: r_version <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_fill  <= '0;
            r_last  <= 1'b0;
            r_scan  <= '0;
            r_frag  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_fill <= fill_inc;
                        if (frame_due) begin
                            r_last  <= i_in.end_of_scan;
                            r_idx   <= '0;
                            r_state <= S_CRC;
                        end
                    end
                end
                S_CRC: begin
                    if (idx_last_crc) begin
                        r_idx   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_EMIT: begin
                    if (emit_adv) begin
                        r_idx <= r_idx + IW'(1);
                        if (idx_last_frame) begin
                            r_state <= S_IDLE;
                            r_fill  <= '0;
                            if (r_last) begin
                                r_scan <= r_scan + 8'd1;
                                r_frag <= '0;
                            end else begin
                                r_frag <= r_frag + 8'd1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register: hold until the sink takes the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_adv) begin
            r_out_byte <= cur_byte;
            r_out_end  <= idx_last_frame;
        end
    end

    assign o_frame.valid      = r_out_valid;
    assign o_frame.frame_byte = r_out_byte;
    assign o_frame.frame_end  = r_out_end;

endmodule
